>>> hw/rtl/bba_pkg.sv
// bba_pkg: shared widths, codes and controller/datapath interface types for
// the block bitmap allocator. No dependencies; imported by every module.
`default_nettype none

package bba_pkg;

  // Fixed field widths
  localparam int IN_BLK_W  = 12;  // block_number / granted_block
  localparam int OP_W      = 2;
  localparam int STATUS_W  = 2;
  localparam int CFG_W     = 13;  // widest configuration register
  localparam int CFG_IDX_W = 1;

  // Parameter defaults
  localparam int MAX_BLOCKS_DEF = 4096;
  localparam int WORD_BITS_DEF  = 32;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BLOCKS    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RESERVED_BLOCKS = 1'b1;
  localparam logic [CFG_W-1:0]     TOTAL_RESET         = 13'd4096;
  localparam logic [CFG_W-1:0]     RESERVED_RESET      = 13'd0;

  // Request codes
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_FORMAT = 2'd2
  } op_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_DOUBLE = 2'd2,
    ST_RANGE  = 2'd3
  } status_t;

  // Map read port source
  typedef enum logic [1:0] {
    RD_NONE,
    RD_FIRST,
    RD_NEXT,
    RD_FREE
  } rd_sel_t;

  // Map write port source
  typedef enum logic [1:0] {
    WR_NONE,
    WR_ALLOC,
    WR_FREE,
    WR_SWEEP
  } wr_sel_t;

  // Result register load
  typedef enum logic [2:0] {
    RES_NONE,
    RES_GRANT,
    RES_FULL,
    RES_FREE,
    RES_RANGE,
    RES_OK
  } res_sel_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic     cap;        // latch block_number of the accepted item
    logic     div;        // register the word-index estimate
    rd_sel_t  rd;
    wr_sel_t  wr;
    logic     sweep_fmt;  // sweep writes the reserved pattern, else zeros
    res_sel_t res;
  } bba_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic range;       // incoming block_number is out of range
    logic hit;         // scanned word holds a grantable free block
    logic scan_end;    // scan is over with nothing to grant
    logic sweep_last;  // sweep is at the last map word
  } bba_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/bba_datapath.sv
// bba_datapath: map memory, scan/free/sweep datapath, config and result regs.
// Depends on bba_pkg; driven by bba_ctrl through bba_cmd_t / bba_stat_t.
`default_nettype none

module bba_datapath import bba_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int WORD_BITS  = WORD_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic [IN_BLK_W-1:0]  in_block_number,
  input  wire bba_cmd_t             cmd,
  output bba_stat_t                 stat,
  output logic [IN_BLK_W-1:0]       out_granted_block,
  output logic [STATUS_W-1:0]       out_status
);

  localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BW        = $clog2(WORD_BITS);
  localparam int LIM_W     = $clog2(MAX_BLOCKS + 1);
  localparam int SPAN_W    = $clog2(MAP_WORDS * WORD_BITS + 1);
  localparam int XW0       = (LIM_W > CFG_W) ? LIM_W : CFG_W;
  localparam int XW        = (SPAN_W > XW0) ? SPAN_W : XW0;
  // block / WORD_BITS by reciprocal multiply, one correction step
  localparam int DIV_S     = IN_BLK_W + 6;
  localparam int RW        = DIV_S - 2;
  localparam int RECIP     = (1 << DIV_S) / WORD_BITS;
  localparam int PW        = IN_BLK_W + RW;

  // Configuration registers
  logic [CFG_W-1:0] total_r;
  logic [CFG_W-1:0] reserved_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r    <= TOTAL_RESET;
      reserved_r <= RESERVED_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TOTAL_BLOCKS:    total_r    <= cfg_wdata;
        REG_RESERVED_BLOCKS: reserved_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Limits clamped to the map size
  logic [XW-1:0] lim;
  logic [XW-1:0] n_res;
  assign lim   = (XW'(total_r) > XW'(MAX_BLOCKS)) ? XW'(MAX_BLOCKS) : XW'(total_r);
  assign n_res = (XW'(reserved_r) > XW'(MAX_BLOCKS)) ? XW'(MAX_BLOCKS) : XW'(reserved_r);

  assign stat.range = XW'(in_block_number) >= lim;

  // Map memory and its registered read port
  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rd_data_r;
  logic [AW-1:0]        rd_word_r;
  logic [AW-1:0]        rd_addr;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  // Free path: word index and bit of the latched block number
  logic [IN_BLK_W-1:0] bno_r;
  logic [AW-1:0]       q_est_r;
  logic [BW-1:0]       bit_r;
  logic [PW-1:0]       prod;
  logic [XW-1:0]       rem;
  logic                fix;
  logic [AW-1:0]       q_fix;
  logic [BW-1:0]       bit_fix;

  assign prod    = PW'(bno_r) * PW'(RECIP);
  assign rem     = XW'(bno_r) - XW'(q_est_r) * XW'(WORD_BITS);
  assign fix     = rem >= XW'(WORD_BITS);
  assign q_fix   = q_est_r + AW'(fix);
  assign bit_fix = fix ? BW'(rem - XW'(WORD_BITS)) : BW'(rem);

  // Scan: lowest clear bit of the word just read
  logic [AW-1:0]  scan_addr_r;
  logic           zero_any;
  logic [BW-1:0]  zero_idx;
  logic [XW-1:0]  word_base;
  logic [XW-1:0]  next_base;
  logic [XW-1:0]  cand;

  always_comb begin
    zero_any = 1'b0;
    zero_idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!rd_data_r[i]) begin
        zero_any = 1'b1;
        zero_idx = BW'(i);
      end
    end
  end

  assign word_base     = XW'(rd_word_r) * XW'(WORD_BITS);
  assign next_base     = word_base + XW'(WORD_BITS);
  assign cand          = word_base + XW'(zero_idx);
  assign stat.hit      = zero_any && (cand < lim);
  assign stat.scan_end = !stat.hit && (zero_any || (next_base >= lim));

  // Sweep: rewrite every word, zeros or the reserved prefix
  logic [AW-1:0]        sweep_r;
  logic [XW-1:0]        n_eff;
  logic [XW-1:0]        sw_base;
  logic [XW-1:0]        sw_top;
  logic [BW-1:0]        sw_lo;
  logic [WORD_BITS-1:0] sweep_word;

  assign stat.sweep_last = sweep_r == AW'(MAP_WORDS - 1);
  assign n_eff   = cmd.sweep_fmt ? n_res : '0;
  assign sw_base = XW'(sweep_r) * XW'(WORD_BITS);
  assign sw_top  = sw_base + XW'(WORD_BITS);
  assign sw_lo   = BW'(n_eff - sw_base);

  always_comb begin
    if (n_eff >= sw_top) begin
      sweep_word = '1;
    end else if (n_eff > sw_base) begin
      sweep_word = ~({WORD_BITS{1'b1}} << sw_lo);
    end else begin
      sweep_word = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
    end else if (cmd.wr == WR_SWEEP) begin
      sweep_r <= stat.sweep_last ? '0 : sweep_r + AW'(1);
    end
  end

  // Read address select
  always_comb begin
    case (cmd.rd)
      RD_FIRST: rd_addr = '0;
      RD_NEXT:  rd_addr = scan_addr_r;
      RD_FREE:  rd_addr = q_fix;
      default:  rd_addr = '0;
    endcase
  end

  // Write select
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = rd_word_r;
    wr_data = rd_data_r;
    case (cmd.wr)
      WR_ALLOC: wr_data = rd_data_r | (WORD_BITS'(1) << zero_idx);
      WR_FREE:  wr_data = rd_data_r & ~(WORD_BITS'(1) << bit_r);
      WR_SWEEP: begin
        wr_addr = sweep_r;
        wr_data = sweep_word;
      end
      default:  wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd != RD_NONE) begin
      rd_data_r <= mem[rd_addr];
      rd_word_r <= rd_addr;
    end
  end

  // Payload registers of the free and scan paths
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      bno_r <= in_block_number;
    end
    if (cmd.div) begin
      q_est_r <= AW'(prod >> DIV_S);
    end
    if (cmd.rd == RD_FREE) begin
      bit_r <= bit_fix;
    end
    if (cmd.rd == RD_FIRST) begin
      scan_addr_r <= AW'(1);
    end else if (cmd.rd == RD_NEXT) begin
      scan_addr_r <= scan_addr_r + AW'(1);
    end
  end

  // Result registers
  logic [IN_BLK_W-1:0] granted_r;
  logic [STATUS_W-1:0] status_r;

  always_ff @(posedge clk) begin
    case (cmd.res)
      RES_GRANT: begin
        granted_r <= cand[IN_BLK_W-1:0];
        status_r  <= ST_OK;
      end
      RES_FULL: begin
        granted_r <= '0;
        status_r  <= ST_FULL;
      end
      RES_FREE: begin
        granted_r <= '0;
        status_r  <= rd_data_r[bit_r] ? ST_OK : ST_DOUBLE;
      end
      RES_RANGE: begin
        granted_r <= '0;
        status_r  <= ST_RANGE;
      end
      RES_OK: begin
        granted_r <= '0;
        status_r  <= ST_OK;
      end
      default: ;
    endcase
  end

  assign out_granted_block = granted_r;
  assign out_status        = status_r;

endmodule

`default_nettype wire

>>> hw/rtl/bba_ctrl.sv
// bba_ctrl: request sequencer for the block bitmap allocator.
// Depends on bba_pkg; commands bba_datapath, owns busy and the result strobe.
`default_nettype none

module bba_ctrl import bba_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [OP_W-1:0] in_operation,
  input  wire bba_stat_t       stat,
  output bba_cmd_t             cmd,
  output logic                 busy,
  output logic                 out_valid
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE_DIV,
    S_FREE_RD,
    S_FREE_WB,
    S_FORMAT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;

  // Next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.rd        = RD_NONE;
    cmd.wr        = WR_NONE;
    cmd.res       = RES_NONE;
    case (state_r)
      S_CLEAR: begin
        cmd.wr = WR_SWEEP;
        if (stat.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.cap = 1'b1;
          case (in_operation)
            OP_ALLOC: begin
              cmd.rd    = RD_FIRST;
              state_nxt = S_SCAN;
            end
            OP_FREE: begin
              if (stat.range) begin
                cmd.res = RES_RANGE;
              end else begin
                state_nxt = S_FREE_DIV;
              end
            end
            OP_FORMAT: state_nxt = S_FORMAT;
            default:   cmd.res = RES_OK;
          endcase
        end
      end
      S_SCAN: begin
        // read of the next word overlaps evaluation of the current one
        cmd.rd = RD_NEXT;
        if (stat.hit) begin
          cmd.wr    = WR_ALLOC;
          cmd.res   = RES_GRANT;
          state_nxt = S_IDLE;
        end else if (stat.scan_end) begin
          cmd.res   = RES_FULL;
          state_nxt = S_IDLE;
        end
      end
      S_FREE_DIV: begin
        cmd.div   = 1'b1;
        state_nxt = S_FREE_RD;
      end
      S_FREE_RD: begin
        cmd.rd    = RD_FREE;
        state_nxt = S_FREE_WB;
      end
      S_FREE_WB: begin
        cmd.wr    = WR_FREE;
        cmd.res   = RES_FREE;
        state_nxt = S_IDLE;
      end
      S_FORMAT: begin
        cmd.wr        = WR_SWEEP;
        cmd.sweep_fmt = 1'b1;
        if (stat.sweep_last) begin
          cmd.res   = RES_OK;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.res != RES_NONE;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/block_bitmap_allocator.sv
// block_bitmap_allocator: first-fit disk block allocator over an in-use bitmap.
// Depends on bba_pkg; instantiates bba_ctrl and bba_datapath.
//
//   channel   ports                                      handshake
//   request   in_operation, in_block_number              start & !busy
//   result    out_granted_block, out_status              out_valid, one cycle
//   config    cfg_index, cfg_wdata                       cfg_we
//
// One request at a time; multi-cycle requests hold busy high from acceptance
// until the result cycle.
// Allocate: the map RAM is read one word per cycle from word 0, and the lowest
// clear bit below the block limit is granted. Free: the word index is estimated,
// the word is read, then written back with the bit cleared. Format: one word is
// written per cycle. Unused code and out-of-range free: answered with busy low.
// After reset a clearing pass runs with busy high. Results cannot be stalled.
`default_nettype none

module block_bitmap_allocator import bba_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int WORD_BITS  = WORD_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [OP_W-1:0]      in_operation,
  input  wire logic [IN_BLK_W-1:0]  in_block_number,
  output logic                      out_valid,
  output logic [IN_BLK_W-1:0]       out_granted_block,
  output logic [STATUS_W-1:0]       out_status,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  bba_cmd_t  cmd;
  bba_stat_t stat;

  // Sequencer
  bba_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .stat         (stat),
    .cmd          (cmd),
    .busy         (busy),
    .out_valid    (out_valid)
  );

  // Map and datapath
  bba_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .WORD_BITS  (WORD_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_block_number   (in_block_number),
    .cmd               (cmd),
    .stat              (stat),
    .out_granted_block (out_granted_block),
    .out_status        (out_status)
  );

endmodule

`default_nettype wire
